>>> rtl/tos_pkg.sv
package tos_pkg;

   // Field and register widths.
   localparam int WORD_W     = 32;
   localparam int REG_W      = 16;
   localparam int CSR_IDX_W  = 2;

   // Shared divider sizing: the expected-position quotient has the widest dividend.
   localparam int DIVIDEND_W = 48;
   localparam int DIVISOR_W  = 17;
   localparam int REM_W      = DIVISOR_W;
   localparam int STEP_W     = 5;

   // Signed widths of the expected-position arithmetic.
   localparam int PROD_B_W   = 50;
   localparam int EXP_W      = 51;

   // Divider run lengths, two quotient bits per cycle.
   localparam logic [STEP_W-1:0] DIV_LONG_STEPS  = STEP_W'(DIVIDEND_W / 2);
   localparam logic [STEP_W-1:0] DIV_SHORT_STEPS = STEP_W'(WORD_W / 2);

   // Register reset values.
   localparam logic [REG_W-1:0] PULSES_RESET      = 16'd100;
   localparam logic [REG_W-1:0] SECTION_LEN_RESET = 16'd125;
   localparam logic [REG_W-1:0] SPACING_RESET     = 16'd600;
   localparam logic [REG_W-1:0] ERR_WIN_RESET     = 16'd20;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PULSES      = 2'd0,
      CSR_SECTION_LEN = 2'd1,
      CSR_SPACING     = 2'd2,
      CSR_ERR_WIN     = 2'd3
   } csr_index_type;

   // Controller states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_PRODUCT,
      S_DIV_EXP,
      S_WAIT_EXP,
      S_EXPECT,
      S_CHECK,
      S_DIV_CEIL,
      S_WAIT_CEIL,
      S_FIX,
      S_EMIT
   } tos_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic exec;
      logic product;
      logic div_start;
      logic div_ceil;
      logic expect_load;
      logic fix;
      logic emit;
   } tos_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic check_pending;
      logic out_of_window;
      logic div_busy;
      logic rsp_free;
   } tos_status_type;

   // Add two counter values and clamp at the all-ones value.
   function automatic logic [WORD_W-1:0] sat_add32(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
      logic [WORD_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[WORD_W] ? {WORD_W{1'b1}} : sum[WORD_W-1:0];
   endfunction

endpackage

>>> rtl/tos_div.sv
module tos_div
   import tos_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   input  logic [STEP_W-1:0]     steps,
   output logic                  busy,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [REM_W-1:0]      remainder
);

   logic                  busy_ff, busy_in;
   logic [STEP_W-1:0]     cnt_ff, cnt_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] dq_ff, dq_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;

   logic [REM_W:0]        sh1, sh2;
   logic [REM_W-1:0]      r1, r2;
   logic                  q1, q2;

   // Two restoring steps per cycle; quotient bits shift in behind the dividend.
   always_comb begin
      sh1 = {rem_ff, dq_ff[DIVIDEND_W-1]};
      q1  = (sh1 >= {1'b0, divisor_ff});
      r1  = q1 ? REM_W'(sh1 - {1'b0, divisor_ff}) : sh1[REM_W-1:0];
      sh2 = {r1, dq_ff[DIVIDEND_W-2]};
      q2  = (sh2 >= {1'b0, divisor_ff});
      r2  = q2 ? REM_W'(sh2 - {1'b0, divisor_ff}) : sh2[REM_W-1:0];
   end

   // Next values for the run control and the working registers.
   always_comb begin
      busy_in    = busy_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      dq_in      = dq_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = steps;
         rem_in     = '0;
         dq_in      = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in = r2;
         dq_in  = {dq_ff[DIVIDEND_W-3:0], q1, q2};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // Run control.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      dq_ff      <= dq_in;
      divisor_ff <= divisor_in;
   end

   assign busy      = busy_ff;
   assign quotient  = dq_ff;
   assign remainder = rem_ff;

   // A new division is never started on top of one in progress.
   assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("divider started while busy");

   // A run ends only when its last step has been taken.
   assert property (@(posedge clock) disable iff (reset)
                    $fell(busy_ff) |-> $past(cnt_ff) == STEP_W'(1))
      else $error("divider finished early");

endmodule

>>> rtl/tos_dp.sv
module tos_dp
   import tos_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_data,
   input  logic                 req_cmd,
   input  logic                 req_edge_a,
   input  logic                 req_edge_b,
   input  logic                 req_sensor_one,
   input  logic                 req_sensor_two,
   input  logic                 rsp_stall,
   input  tos_cmd_type          cmd,
   output tos_status_type       status,
   output logic                 rsp_valid,
   output logic                 rsp_calibration_point,
   output logic [WORD_W-1:0]    rsp_section_count,
   output logic [WORD_W-1:0]    rsp_encoder_distance,
   output logic [WORD_W-1:0]    rsp_sleeper_distance_now,
   output logic [WORD_W-1:0]    rsp_sleeper_count,
   output logic                 rsp_position_corrected
);

   // Configuration registers.
   logic [REG_W-1:0] pulses_ff, section_len_ff, spacing_ff, err_win_ff;

   // Captured input beat.
   logic in_cmd_ff, in_ea_ff, in_eb_ff, in_s1_ff, in_s2_ff;

   // Odometer state.
   logic [WORD_W-1:0] edge_ff, edge_in;
   logic [WORD_W-1:0] sections_ff, sections_in;
   logic [WORD_W-1:0] enc_ff, enc_in;
   logic [WORD_W-1:0] slp_ff, slp_in;
   logic [WORD_W-1:0] slp_cnt_ff, slp_cnt_in;
   logic              first_ff, first_in;
   logic              armed_ff, armed_in;

   // Per-item flags.
   logic cal_ff, cal_in, corr_ff, corr_in, check_ff, check_in;

   // Expected-position working registers.
   logic [DIVIDEND_W-1:0]      prod_a_ff;
   logic signed [PROD_B_W-1:0] prod_b_ff;
   logic signed [EXP_W-1:0]    expected_ff;

   // Result register.
   logic              rsp_valid_ff;
   logic              rsp_cal_ff, rsp_corr_ff;
   logic [WORD_W-1:0] rsp_sections_ff, rsp_enc_ff, rsp_slp_ff, rsp_slp_cnt_ff;

   // Derived values.
   logic [REG_W-1:0]           p_eff, len_eff;
   logic [REG_W+1:0]           trig_limit;
   logic [WORD_W-1:0]          edge_sum, sec_inc, cnt_inc;
   logic                       detect;
   logic [DIVIDEND_W-1:0]      prod_a_in;
   logic signed [WORD_W:0]     sec_m1;
   logic signed [REG_W:0]      len_s;
   logic signed [PROD_B_W-1:0] prod_b_in;
   logic signed [EXP_W-1:0]    expected_in, dist_s, win_s;

   // Divider hookup.
   logic [DIVIDEND_W-1:0] div_dividend, div_quot;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic [STEP_W-1:0]     div_steps;
   logic [REM_W-1:0]      div_rem;
   logic                  div_busy;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         pulses_ff      <= PULSES_RESET;
         section_len_ff <= SECTION_LEN_RESET;
         spacing_ff     <= SPACING_RESET;
         err_win_ff     <= ERR_WIN_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PULSES:      pulses_ff      <= csr_data;
            CSR_SECTION_LEN: section_len_ff <= csr_data;
            CSR_SPACING:     spacing_ff     <= csr_data;
            CSR_ERR_WIN:     err_win_ff     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Input beat capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_cmd_ff <= req_cmd;
         in_ea_ff  <= req_edge_a;
         in_eb_ff  <= req_edge_b;
         in_s1_ff  <= req_sensor_one;
         in_s2_ff  <= req_sensor_two;
      end
   end

   // A zero pulse count or section length counts as one.
   assign p_eff      = (pulses_ff == '0) ? REG_W'(1) : pulses_ff;
   assign len_eff    = (section_len_ff == '0) ? REG_W'(1) : section_len_ff;
   assign trig_limit = {({1'b0, p_eff} + (REG_W + 1)'(1)), 1'b0};

   assign edge_sum = sat_add32(edge_ff, {{(WORD_W-1){1'b0}}, in_ea_ff} +
                                        {{(WORD_W-1){1'b0}}, in_eb_ff});
   assign sec_inc  = sat_add32(sections_ff, WORD_W'(1));
   assign cnt_inc  = sat_add32(slp_cnt_ff, WORD_W'(1));
   assign detect   = armed_ff && in_s1_ff && in_s2_ff;

   // Item update, and the section fix after a failed position check.
   always_comb begin
      edge_in     = edge_ff;
      sections_in = sections_ff;
      enc_in      = enc_ff;
      slp_in      = slp_ff;
      slp_cnt_in  = slp_cnt_ff;
      first_in    = first_ff;
      armed_in    = armed_ff;
      cal_in      = cal_ff;
      corr_in     = corr_ff;
      check_in    = check_ff;
      if (cmd.exec) begin
         cal_in   = 1'b0;
         corr_in  = 1'b0;
         check_in = 1'b0;
         if (!in_cmd_ff) begin
            // Encoder edge beat: count, then test the calibration threshold.
            if ((edge_sum >= WORD_W'(trig_limit)) && first_ff) begin
               cal_in      = 1'b1;
               sections_in = sec_inc;
               if (sec_inc > WORD_W'(1)) begin
                  enc_in = sat_add32(enc_ff, WORD_W'(len_eff));
               end
               edge_in = '0;
            end else begin
               edge_in = edge_sum;
            end
         end else begin
            // Sleeper sample beat: detect on both high, re-arm on both low.
            if (detect) begin
               armed_in   = 1'b0;
               first_in   = 1'b1;
               slp_cnt_in = cnt_inc;
               if (cnt_inc > WORD_W'(1)) begin
                  slp_in   = sat_add32(slp_ff, WORD_W'(spacing_ff));
                  check_in = 1'b1;
               end
            end else if (!in_s1_ff && !in_s2_ff) begin
               armed_in = 1'b1;
            end
         end
      end
      if (cmd.fix) begin
         sections_in = div_quot[WORD_W-1:0] + WORD_W'(div_rem != '0);
         corr_in     = 1'b1;
      end
   end

   // Odometer state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff     <= '0;
         sections_ff <= '0;
         enc_ff      <= '0;
         slp_ff      <= '0;
         slp_cnt_ff  <= '0;
         first_ff    <= 1'b0;
         armed_ff    <= 1'b1;
         cal_ff      <= 1'b0;
         corr_ff     <= 1'b0;
         check_ff    <= 1'b0;
      end else begin
         edge_ff     <= edge_in;
         sections_ff <= sections_in;
         enc_ff      <= enc_in;
         slp_ff      <= slp_in;
         slp_cnt_ff  <= slp_cnt_in;
         first_ff    <= first_in;
         armed_ff    <= armed_in;
         cal_ff      <= cal_in;
         corr_ff     <= corr_in;
         check_ff    <= check_in;
      end
   end

   // Products for the expected position: edges times length, and whole sections.
   assign prod_a_in = {{(DIVIDEND_W-WORD_W){1'b0}}, edge_ff} *
                      {{(DIVIDEND_W-REG_W){1'b0}}, len_eff};
   assign sec_m1    = $signed({1'b0, sections_ff}) - (WORD_W + 1)'(1);
   assign len_s     = $signed({1'b0, len_eff});
   assign prod_b_in = sec_m1 * len_s;

   always_ff @(posedge clock) begin
      if (cmd.product) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
      end
   end

   // Divider operands: fraction of a section, or the rounded-up section count.
   assign div_dividend = cmd.div_ceil ? {slp_ff, {(DIVIDEND_W-WORD_W){1'b0}}} : prod_a_ff;
   assign div_divisor  = cmd.div_ceil ? {1'b0, len_eff} : {p_eff, 1'b0};
   assign div_steps    = cmd.div_ceil ? DIV_SHORT_STEPS : DIV_LONG_STEPS;

   tos_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .steps     (div_steps),
      .busy      (div_busy),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // Expected position and the window test against the sleeper distance.
   assign expected_in = $signed({{(EXP_W-PROD_B_W){prod_b_ff[PROD_B_W-1]}}, prod_b_ff}) +
                        $signed({{(EXP_W-DIVIDEND_W){1'b0}}, div_quot});
   assign dist_s      = $signed({{(EXP_W-WORD_W){1'b0}}, slp_ff});
   assign win_s       = $signed({{(EXP_W-REG_W){1'b0}}, err_win_ff});

   always_ff @(posedge clock) begin
      if (cmd.expect_load) begin
         expected_ff <= expected_in;
      end
   end

   assign status.check_pending = check_ff;
   assign status.out_of_window = (dist_s > expected_ff + win_s) ||
                                 (dist_s < expected_ff - win_s);
   assign status.div_busy      = div_busy;
   assign status.rsp_free      = !rsp_valid_ff || !rsp_stall;

   // Result register: holds a beat until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_cal_ff      <= cal_ff;
         rsp_sections_ff <= sections_ff;
         rsp_enc_ff      <= enc_ff;
         rsp_slp_ff      <= slp_ff;
         rsp_slp_cnt_ff  <= slp_cnt_ff;
         rsp_corr_ff     <= corr_ff;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_calibration_point    = rsp_cal_ff;
   assign rsp_section_count        = rsp_sections_ff;
   assign rsp_encoder_distance     = rsp_enc_ff;
   assign rsp_sleeper_distance_now = rsp_slp_ff;
   assign rsp_sleeper_count        = rsp_slp_cnt_ff;
   assign rsp_position_corrected   = rsp_corr_ff;

   // A loaded result is always presented on the next cycle.
   assert property (@(posedge clock) disable iff (reset) cmd.emit |=> rsp_valid_ff)
      else $error("result loaded but not presented");

   // A section fix only follows a sleeper sample.
   assert property (@(posedge clock) disable iff (reset) cmd.fix |-> in_cmd_ff)
      else $error("section fix on an encoder beat");

   // Calibration and correction never come from the same beat.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid_ff |-> !(rsp_cal_ff && rsp_corr_ff))
      else $error("calibration and correction on one beat");

endmodule

>>> rtl/tos_ctrl.sv
module tos_ctrl
   import tos_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  tos_status_type status,
   output tos_cmd_type    cmd
);

   tos_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_PRODUCT;
         end
         S_PRODUCT: begin
            cmd.product = 1'b1;
            state_in    = status.check_pending ? S_DIV_EXP : S_EMIT;
         end
         S_DIV_EXP: begin
            cmd.div_start = 1'b1;
            state_in      = S_WAIT_EXP;
         end
         S_WAIT_EXP: begin
            if (!status.div_busy) begin
               state_in = S_EXPECT;
            end
         end
         S_EXPECT: begin
            cmd.expect_load = 1'b1;
            state_in        = S_CHECK;
         end
         S_CHECK: begin
            state_in = status.out_of_window ? S_DIV_CEIL : S_EMIT;
         end
         S_DIV_CEIL: begin
            cmd.div_start = 1'b1;
            cmd.div_ceil  = 1'b1;
            state_in      = S_WAIT_CEIL;
         end
         S_WAIT_CEIL: begin
            cmd.div_ceil = 1'b1;
            if (!status.div_busy) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            cmd.fix  = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

>>> rtl/track_odometer_with_sleeper_correction.sv
// Track odometer with sleeper correction.
// The req_ channel carries one beat per event: an encoder edge beat (req_cmd low,
// req_edge_a and req_edge_b) or a sleeper sensor beat (req_cmd high, req_sensor_one
// and req_sensor_two). A beat moves when valid is high and stall is low.
// Every input beat yields exactly one rsp_ beat with the updated counters and
// the calibration and correction flags.
// The csr_ port writes the four 16-bit constants by index; write only while idle.
// An encoder beat, or a sleeper beat with no position check, passes the exec,
// product and emit states after acceptance before it reaches the result register,
// and the block takes the next beat only once it is back in idle. A sleeper beat
// that checks the position also runs the shared divider for the expected position,
// and again for the rounded-up section count when it corrects that count. The
// divider yields two quotient bits per cycle.
// The result register parts the two sides: a new beat is taken while a result
// waits under stall, and the next result waits in the datapath until it drains.
// Reset is synchronous: all counters clear, the sleeper detector is armed and
// the constants return to 100, 125, 600 and 20.
module track_odometer_with_sleeper_correction
   import tos_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_cmd,
   input  logic                 req_edge_a,
   input  logic                 req_edge_b,
   input  logic                 req_sensor_one,
   input  logic                 req_sensor_two,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_calibration_point,
   output logic [WORD_W-1:0]    rsp_section_count,
   output logic [WORD_W-1:0]    rsp_encoder_distance,
   output logic [WORD_W-1:0]    rsp_sleeper_distance_now,
   output logic [WORD_W-1:0]    rsp_sleeper_count,
   output logic                 rsp_position_corrected
);

   tos_cmd_type    cmd;
   tos_status_type status;

   // Sequencer.
   tos_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Counters, arithmetic and result register.
   tos_dp u_dp (
      .clock                    (clock),
      .reset                    (reset),
      .csr_we                   (csr_we),
      .csr_index                (csr_index),
      .csr_data                 (csr_data),
      .req_cmd                  (req_cmd),
      .req_edge_a               (req_edge_a),
      .req_edge_b               (req_edge_b),
      .req_sensor_one           (req_sensor_one),
      .req_sensor_two           (req_sensor_two),
      .rsp_stall                (rsp_stall),
      .cmd                      (cmd),
      .status                   (status),
      .rsp_valid                (rsp_valid),
      .rsp_calibration_point    (rsp_calibration_point),
      .rsp_section_count        (rsp_section_count),
      .rsp_encoder_distance     (rsp_encoder_distance),
      .rsp_sleeper_distance_now (rsp_sleeper_distance_now),
      .rsp_sleeper_count        (rsp_sleeper_count),
      .rsp_position_corrected   (rsp_position_corrected)
   );

endmodule

>>> verif/odometer_checker.sv
`timescale 1ns / 1ps
module odometer_checker
   import tos_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_data,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic                 req_cmd,
   input  logic                 req_edge_a,
   input  logic                 req_edge_b,
   input  logic                 req_sensor_one,
   input  logic                 req_sensor_two,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 rsp_calibration_point,
   input  logic [WORD_W-1:0]    rsp_section_count,
   input  logic [WORD_W-1:0]    rsp_encoder_distance,
   input  logic [WORD_W-1:0]    rsp_sleeper_distance_now,
   input  logic [WORD_W-1:0]    rsp_sleeper_count,
   input  logic                 rsp_position_corrected,
   output int unsigned          mismatch_count,
   output int unsigned          results_owed
);

   // One odometer reading as it should leave the result channel.
   typedef struct packed {
      logic              calibration_point;
      logic [WORD_W-1:0] section_count;
      logic [WORD_W-1:0] encoder_distance;
      logic [WORD_W-1:0] sleeper_travel;
      logic [WORD_W-1:0] sleeper_count;
      logic              position_corrected;
   } odo_reading_type;

   localparam longint unsigned COUNTER_MAX = 64'h0000_0000_FFFF_FFFF;

   // Shadow copy of the constants, written by watching the register port.
   logic [REG_W-1:0]  pulses_cfg;
   logic [REG_W-1:0]  length_cfg;
   logic [REG_W-1:0]  spacing_cfg;
   logic [REG_W-1:0]  window_cfg;

   // Shadow copy of the odometer state.
   logic [WORD_W-1:0] edge_tally;
   logic [WORD_W-1:0] section_tally;
   logic [WORD_W-1:0] encoder_odo;
   logic [WORD_W-1:0] sleeper_odo;
   logic [WORD_W-1:0] sleeper_tally;
   logic              first_sleeper_seen;
   logic              detector_ready;

   odo_reading_type   pending_readings[$];
   int unsigned       errors;
   int unsigned       readings_seen;

   // Counters and distances stick at the all-ones value instead of wrapping.
   function automatic logic [WORD_W-1:0] clamp_sum(input logic [WORD_W-1:0] a,
                                                   input longint unsigned b);
      longint unsigned total;
      total = a + b;
      return (total > COUNTER_MAX) ? COUNTER_MAX[WORD_W-1:0] : total[WORD_W-1:0];
   endfunction

   // Apply one input beat to the shadow state and return the reading it should produce.
   task automatic advance_odometer(input logic cmd, input logic ea, input logic eb,
                                   input logic s1, input logic s2,
                                   output odo_reading_type res);
      longint unsigned   pulses;
      longint unsigned   len;
      longint            len_s;
      longint            frac;
      longint            want_pos;
      longint            have_pos;
      longint            margin;
      longint            sec_pos;
      logic [WORD_W-1:0] len_word;
      logic [WORD_W-1:0] ceil_q;

      // A zero constant behaves as one.
      pulses = (pulses_cfg == '0) ? 64'd1 : 64'(pulses_cfg);
      len    = (length_cfg == '0) ? 64'd1 : 64'(length_cfg);
      len_s  = len;
      res    = '0;

      if (cmd == 1'b0) begin
         // The threshold is tested on every encoder beat, even one with no edge.
         edge_tally = clamp_sum(edge_tally, 64'(ea) + 64'(eb));
         if (first_sleeper_seen && (64'(edge_tally) >= 2 * (pulses + 1))) begin
            res.calibration_point = 1'b1;
            section_tally = clamp_sum(section_tally, 64'd1);
            if (section_tally > 1)
               encoder_odo = clamp_sum(encoder_odo, len);
            edge_tally = '0;
         end
      end else begin
         if (detector_ready && s1 && s2) begin
            detector_ready     = 1'b0;
            first_sleeper_seen = 1'b1;
            sleeper_tally      = clamp_sum(sleeper_tally, 64'd1);
            if (sleeper_tally > 1) begin
               sleeper_odo = clamp_sum(sleeper_odo, 64'(spacing_cfg));
               // Signed expected position: with no section yet it starts one length behind.
               sec_pos  = section_tally;
               frac     = (64'(edge_tally) * len) / (2 * pulses);
               want_pos = (sec_pos - 1) * len_s + frac;
               have_pos = sleeper_odo;
               margin   = window_cfg;
               if ((have_pos > want_pos + margin) || (have_pos < want_pos - margin)) begin
                  len_word = len[WORD_W-1:0];
                  ceil_q   = sleeper_odo / len_word;
                  if ((sleeper_odo % len_word) != '0)
                     ceil_q = ceil_q + 1;
                  section_tally          = ceil_q;
                  res.position_corrected = 1'b1;
               end
            end
         end
         // Both sensors low re-arms the detector.
         if (!detector_ready && !s1 && !s2)
            detector_ready = 1'b1;
      end

      res.section_count    = section_tally;
      res.encoder_distance = encoder_odo;
      res.sleeper_travel   = sleeper_odo;
      res.sleeper_count    = sleeper_tally;
   endtask

   task automatic report_mismatch(input string what);
      errors++;
      if (errors <= 100)
         $display("%0t ns: reading %0d: %s", $time, readings_seen, what);
   endtask

   task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                              input logic [WORD_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
   endtask

   // Watch the register port and both channels; results are checked before new beats are
   // predicted so a stray result can never be matched against a beat taken at the same edge.
   always @(posedge clock) begin : watch
      odo_reading_type want;
      odo_reading_type next_reading;
      if (reset) begin
         pulses_cfg         = PULSES_RESET;
         length_cfg         = SECTION_LEN_RESET;
         spacing_cfg        = SPACING_RESET;
         window_cfg         = ERR_WIN_RESET;
         edge_tally         = '0;
         section_tally      = '0;
         encoder_odo        = '0;
         sleeper_odo        = '0;
         sleeper_tally      = '0;
         first_sleeper_seen = 1'b0;
         detector_ready     = 1'b1;
         pending_readings.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_PULSES:      pulses_cfg  = csr_data;
               CSR_SECTION_LEN: length_cfg  = csr_data;
               CSR_SPACING:     spacing_cfg = csr_data;
               CSR_ERR_WIN:     window_cfg  = csr_data;
               default: ;
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            readings_seen++;
            if (pending_readings.size() == 0) begin
               report_mismatch("result beat arrived with no input beat outstanding");
            end else begin
               want = pending_readings.pop_front();
               check_field("calibration_point", rsp_calibration_point,
                           want.calibration_point);
               check_field("section_count", rsp_section_count, want.section_count);
               check_field("encoder_distance", rsp_encoder_distance, want.encoder_distance);
               check_field("sleeper_distance_now", rsp_sleeper_distance_now,
                           want.sleeper_travel);
               check_field("sleeper_count", rsp_sleeper_count, want.sleeper_count);
               check_field("position_corrected", rsp_position_corrected,
                           want.position_corrected);
            end
         end

         if (req_valid && !req_stall) begin
            advance_odometer(req_cmd, req_edge_a, req_edge_b, req_sensor_one,
                             req_sensor_two, next_reading);
            pending_readings.push_back(next_reading);
         end
      end
      mismatch_count <= errors;
      results_owed   <= pending_readings.size();
   end

endmodule

>>> verif/tb_track_odometer_with_sleeper_correction.sv
`timescale 1ns / 1ps
module tb_track_odometer_with_sleeper_correction;
   import tos_pkg::*;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [REG_W-1:0]     csr_data;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_cmd;
   logic                 req_edge_a;
   logic                 req_edge_b;
   logic                 req_sensor_one;
   logic                 req_sensor_two;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_calibration_point;
   logic [WORD_W-1:0]    rsp_section_count;
   logic [WORD_W-1:0]    rsp_encoder_distance;
   logic [WORD_W-1:0]    rsp_sleeper_distance_now;
   logic [WORD_W-1:0]    rsp_sleeper_count;
   logic                 rsp_position_corrected;

   int unsigned          mismatch_count;
   int unsigned          results_owed;
   int unsigned          beats_sent;
   int unsigned          stall_left;
   int unsigned          stall_pick;
   bit                   steady_send;
   bit                   steady_drain;

   track_odometer_with_sleeper_correction u_top (
      .clock                    (clock),
      .reset                    (reset),
      .csr_we                   (csr_we),
      .csr_index                (csr_index),
      .csr_data                 (csr_data),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_cmd                  (req_cmd),
      .req_edge_a               (req_edge_a),
      .req_edge_b               (req_edge_b),
      .req_sensor_one           (req_sensor_one),
      .req_sensor_two           (req_sensor_two),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_calibration_point    (rsp_calibration_point),
      .rsp_section_count        (rsp_section_count),
      .rsp_encoder_distance     (rsp_encoder_distance),
      .rsp_sleeper_distance_now (rsp_sleeper_distance_now),
      .rsp_sleeper_count        (rsp_sleeper_count),
      .rsp_position_corrected   (rsp_position_corrected)
   );

   odometer_checker u_checker (
      .clock                    (clock),
      .reset                    (reset),
      .csr_we                   (csr_we),
      .csr_index                (csr_index),
      .csr_data                 (csr_data),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_cmd                  (req_cmd),
      .req_edge_a               (req_edge_a),
      .req_edge_b               (req_edge_b),
      .req_sensor_one           (req_sensor_one),
      .req_sensor_two           (req_sensor_two),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_calibration_point    (rsp_calibration_point),
      .rsp_section_count        (rsp_section_count),
      .rsp_encoder_distance     (rsp_encoder_distance),
      .rsp_sleeper_distance_now (rsp_sleeper_distance_now),
      .rsp_sleeper_count        (rsp_sleeper_count),
      .rsp_position_corrected   (rsp_position_corrected),
      .mismatch_count           (mismatch_count),
      .results_owed             (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case a result never arrives.
   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic coin();
      return 1'($urandom_range(1));
   endfunction

   function automatic bit chance(input int unsigned percent);
      return $urandom_range(99) < percent;
   endfunction

   // Idle time before a beat: mostly none, sometimes a short gap, rarely a long gap.
   function automatic int unsigned sender_gap();
      int unsigned pick;
      if (steady_send)
         return 0;
      pick = $urandom_range(99);
      if (pick < 60)
         return 0;
      if (pick < 94)
         return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // The receiver stalls in random stretches, with occasional long holds, unless it drains steadily.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (steady_drain) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_pick = $urandom_range(99);
         if (stall_pick < 55) begin
            rsp_stall  <= 1'b0;
            stall_left <= $urandom_range(6, 0);
         end else if (stall_pick < 93) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(2, 0);
         end else begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(60, 15);
         end
      end
   end

   // Present one beat and hold it until the block takes it.
   task automatic send_beat(input logic cmd, input logic ea, input logic eb,
                            input logic s1, input logic s2);
      int unsigned gap;
      gap = sender_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_edge_a     <= ea;
      req_edge_b     <= eb;
      req_sensor_one <= s1;
      req_sensor_two <= s2;
      do @(posedge clock); while (req_stall);
      beats_sent++;
   endtask

   // Stop sending until every outstanding reading has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [REG_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Constants change only once the block has gone quiet.
   task automatic load_constants(input logic [REG_W-1:0] pulses, input logic [REG_W-1:0] len,
                                 input logic [REG_W-1:0] spacing,
                                 input logic [REG_W-1:0] window);
      wait_drained();
      repeat (8) @(posedge clock);
      write_csr(CSR_PULSES, pulses);
      write_csr(CSR_SECTION_LEN, len);
      write_csr(CSR_SPACING, spacing);
      write_csr(CSR_ERR_WIN, window);
   endtask

   // Mostly realistic travel: edge runs followed by a sleeper passing both sensors,
   // with some broken passes and some pure noise mixed in.
   task automatic play_track(input int unsigned budget);
      int unsigned first;
      int unsigned run_len;
      logic        lead;
      first = beats_sent;
      while (beats_sent - first < budget) begin
         if (chance(72)) begin
            run_len = $urandom_range(12, 1);
            repeat (run_len)
               send_beat(1'b0, chance(85) | coin(), chance(85) | coin(), coin(), coin());
            lead = coin();
            if (chance(60))
               send_beat(1'b1, coin(), coin(), lead, !lead);
            repeat ($urandom_range(2, 1))
               send_beat(1'b1, coin(), coin(), 1'b1, 1'b1);
            if (chance(50))
               send_beat(1'b1, coin(), coin(), !lead, lead);
            if (chance(88))
               send_beat(1'b1, coin(), coin(), 1'b0, 1'b0);
         end else begin
            repeat ($urandom_range(4, 1))
               send_beat(coin(), coin(), coin(), coin(), coin());
         end
         if (chance(8))
            wait_drained();
      end
   endtask

   task automatic run_phase(input logic [REG_W-1:0] pulses, input logic [REG_W-1:0] len,
                            input logic [REG_W-1:0] spacing, input logic [REG_W-1:0] window,
                            input int unsigned budget, input bit send_flat,
                            input bit drain_flat);
      load_constants(pulses, len, spacing, window);
      steady_send  = send_flat;
      steady_drain = drain_flat;
      play_track(budget);
   endtask

   initial begin
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_index      <= CSR_PULSES;
      csr_data       <= '0;
      req_valid      <= 1'b0;
      req_cmd        <= 1'b0;
      req_edge_a     <= 1'b0;
      req_edge_b     <= 1'b0;
      req_sensor_one <= 1'b0;
      req_sensor_two <= 1'b0;
      steady_send  = 1'b0;
      steady_drain = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Encoder beats with every edge combination; sensor levels are ignored on them.
      send_beat(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
      send_beat(1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
      send_beat(1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
      send_beat(1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
      // A single sensor never counts; both high passes the first sleeper.
      send_beat(1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
      send_beat(1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
      send_beat(1'b1, 1'b1, 1'b0, 1'b1, 1'b1);
      // The detector stays disarmed until both sensors read low.
      send_beat(1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
      send_beat(1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
      send_beat(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      // Second sleeper before any section: the expected position is negative.
      send_beat(1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
      send_beat(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);

      // Smallest constants: pulse count, length and spacing of one, and no error margin.
      load_constants(16'd1, 16'd1, 16'd1, 16'd0);
      send_beat(1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
      send_beat(1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
      // An encoder beat without edges still tests the threshold.
      send_beat(1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
      send_beat(1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
      send_beat(1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
      send_beat(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);

      // Zero pulses and zero length behave as one; spacing and margin at their maximum.
      load_constants(16'd0, 16'd0, 16'd65535, 16'd65535);
      send_beat(1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
      send_beat(1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
      send_beat(1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
      send_beat(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);

      // Random travel under a series of constant sets, extremes included.
      run_phase(16'd1, 16'd1, 16'd1, 16'd0, 80, 1'b0, 1'b0);
      run_phase(16'd2, 16'd125, 16'd100, 16'd20, 80, 1'b1, 1'b1);
      run_phase(16'd3, 16'd10, 16'd7, 16'd65535, 80, 1'b0, 1'b0);
      run_phase(16'd65535, 16'd65535, 16'd65535, 16'd65535, 60, 1'b0, 1'b1);
      run_phase(16'd4, 16'd50, 16'd25, 16'd5, 80, 1'b0, 1'b0);
      run_phase(16'd1, 16'd3, 16'd2, 16'd1, 80, 1'b1, 1'b0);
      run_phase(16'd5, 16'd1000, 16'd400, 16'd300, 80, 1'b0, 1'b0);
      run_phase(16'd0, 16'd0, 16'd1, 16'd2, 50, 1'b0, 1'b0);
      run_phase(PULSES_RESET, SECTION_LEN_RESET, SPACING_RESET, ERR_WIN_RESET, 40,
                1'b0, 1'b0);

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
